/* design/assert_macros.svh */
// Assertion helpers shared by the RTL. They expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define LFU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define LFU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Plain invariant
`define LFU_ASSERT_ALW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

`endif

/* design/lfu_pkg.sv */
package lfu_pkg;

  localparam int WORD_W  = 32;
  localparam int CNT_W   = 32;
  localparam int STAMP_W = 48;
  localparam int CFG_W   = 5;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [STAMP_W-1:0]       stamp_t;
  typedef logic [CFG_W-1:0]         cfg_t;

  localparam cnt_t CNT_MAX = '1;
  localparam cnt_t CNT_ONE = cnt_t'(1);
  localparam cfg_t CAP_RESET = cfg_t'(16);

  // action codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  // one table slot as held in the entry memory
  typedef struct packed {
    word_t  key;
    word_t  data;
    cnt_t   count;
    stamp_t stamp;
  } entry_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic in_ready;
    logic start;
    logic rd_en;
    logic commit;
  } ctrl_t;

  // compare unit result
  typedef struct packed {
    logic key_eq;
    logic less;
  } cmp_res_t;

endpackage

/* design/lfu_if.sv */
// Request channel
interface lfu_in_if import lfu_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  action;
  word_t key;
  word_t write_value;
  modport source (output valid, action, key, write_value, input ready);
  modport sink (input valid, action, key, write_value, output ready);
endinterface

// Result channel
interface lfu_out_if import lfu_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  hit;
  word_t read_value;
  logic  evicted;
  word_t evicted_key;
  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// Capacity register write channel
interface lfu_cfg_if import lfu_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* design/lfu_cmp_unit.sv */
// Shared slot comparator: key match and victim ordering for one slot per cycle
module lfu_cmp_unit import lfu_pkg::*; (
  input  word_t    probe_key,
  input  entry_t   ent,
  input  logic     best_found,
  input  cnt_t     best_cnt,
  input  stamp_t   best_stamp,
  output cmp_res_t res
);

  // lower count wins, then older stamp; equal keeps the earlier slot
  always_comb begin
    res.key_eq = (ent.key == probe_key);
    res.less   = !best_found || (ent.count < best_cnt) ||
                 ((ent.count == best_cnt) && (ent.stamp < best_stamp));
  end

endmodule

/* design/lfu_ctrl.sv */
// Sequencer: accept, scan every slot, drain the read pipe, commit
module lfu_ctrl import lfu_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             out_free,
  output ctrl_t            ctl,
  output logic [IDX_W-1:0] rd_addr
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t           st_r, st_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // state and scan index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      idx_r <= '0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
    end
  end

  // next state
  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    unique case (st_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_valid) st_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_r == LAST_IDX) begin
          st_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: st_nxt = ST_COMMIT;
      ST_COMMIT: begin
        if (out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl     = '0;
    rd_addr = idx_r;
    unique case (st_r)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
        ctl.start    = in_valid;
      end
      ST_SCAN:   ctl.rd_en  = 1'b1;
      ST_DRAIN:  ctl        = '0;
      ST_COMMIT: ctl.commit = out_free;
      default:   ctl        = '0;
    endcase
  end

endmodule

/* design/lfu_cache_table.sv */
// Fully associative key/value table with least-frequently-used replacement,
// oldest entry first among equal use counts. One request (get or set) is in
// work at a time: after acceptance every slot is read through the single
// read port of the entry memory and run through one shared comparator,
// one slot per cycle, followed by a drain state for the read pipe and a
// commit state that writes back. The next request can be accepted in the
// cycle after the write-back.
// The result sits in an output register; a write-back waits only while a
// previous result has not yet been taken. Valid bits are flip-flops cleared
// by reset, so no clearing pass is needed. The capacity register is taken
// as 1..ENTRIES (0 acts as 1) and should be written only while idle.
`include "assert_macros.svh"

module lfu_cache_table import lfu_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  lfu_in_if.sink     in_ch,
  lfu_out_if.source  out_ch,
  lfu_cfg_if.sink    cfg_ch
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam int CAP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(ENTRIES);
  localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(1);

  ctrl_t            ctl;
  logic [IDX_W-1:0] rd_addr;
  logic             out_free;

  // capacity register
  cfg_t cap_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_ch.valid) begin
      cap_r <= cfg_ch.data;
    end
  end

  // sequencer
  lfu_ctrl #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .ctl      (ctl),
    .rd_addr  (rd_addr)
  );
  assign in_ch.ready = ctl.in_ready;

  // request latch
  logic  act_r;
  word_t key_r, wval_r;
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      act_r  <= in_ch.action;
      key_r  <= in_ch.key;
      wval_r <= in_ch.write_value;
    end
  end

  // entry memory, one read and one write port, registered read
  entry_t           mem [ENTRIES];
  entry_t           rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_entry;
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_idx] <= wr_entry;
    if (ctl.rd_en) rd_data_r <= mem[rd_addr];
  end

  // read pipe tracking
  logic             rd_pend_r;
  logic [IDX_W-1:0] cmp_idx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= ctl.rd_en;
    end
    cmp_idx_r <= rd_addr;
  end

  // valid bits and fill count
  logic [ENTRIES-1:0] valid_r;
  logic [FILL_W-1:0]  fill_r;
  stamp_t             stamp_r;
  logic               set_valid, fill_inc;

  // tracked scan results
  logic             hit_r, free_found_r, vic_found_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r, vic_idx_r;
  word_t            hit_data_r, vic_key_r;
  cnt_t             hit_cnt_r, vic_cnt_r;
  stamp_t           vic_stamp_r;

  // shared comparator
  cmp_res_t cres;
  logic     cur_valid;
  lfu_cmp_unit u_cmp (
    .probe_key  (key_r),
    .ent        (rd_data_r),
    .best_found (vic_found_r),
    .best_cnt   (vic_cnt_r),
    .best_stamp (vic_stamp_r),
    .res        (cres)
  );
  assign cur_valid = valid_r[cmp_idx_r];

  // fold one slot per cycle into the trackers
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.start) begin
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      vic_found_r  <= 1'b0;
    end else if (rd_pend_r) begin
      if (cur_valid && cres.key_eq && !hit_r) begin
        hit_r      <= 1'b1;
        hit_idx_r  <= cmp_idx_r;
        hit_data_r <= rd_data_r.data;
        hit_cnt_r  <= rd_data_r.count;
      end
      if (!cur_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end
      if (cur_valid && cres.less) begin
        vic_found_r <= 1'b1;
        vic_idx_r   <= cmp_idx_r;
        vic_key_r   <= rd_data_r.key;
        vic_cnt_r   <= rd_data_r.count;
        vic_stamp_r <= rd_data_r.stamp;
      end
    end
  end

  // effective capacity and room check
  logic [CAP_W-1:0] cap_ext, cap_eff;
  logic             has_room;
  always_comb begin
    cap_ext = CAP_W'(cap_r);
    if (cap_ext == '0) begin
      cap_eff = CAP_MIN;
    end else if (cap_ext > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = cap_ext;
    end
    has_room = (CAP_W'(fill_r) < cap_eff);
  end

  // write-back decision and result fields
  logic  res_hit, res_evicted, do_write;
  word_t res_rv, res_ek;
  always_comb begin
    do_write       = 1'b0;
    set_valid      = 1'b0;
    fill_inc       = 1'b0;
    wr_idx         = vic_idx_r;
    wr_entry.key   = key_r;
    wr_entry.data  = wval_r;
    wr_entry.count = CNT_ONE;
    wr_entry.stamp = stamp_r;
    res_hit        = 1'b0;
    res_rv         = '1;
    res_evicted    = 1'b0;
    res_ek         = '0;
    priority if (hit_r) begin
      do_write       = 1'b1;
      res_hit        = 1'b1;
      wr_idx         = hit_idx_r;
      wr_entry.count = (hit_cnt_r == CNT_MAX) ? CNT_MAX : hit_cnt_r + CNT_ONE;
      if (act_r == ACT_GET) begin
        wr_entry.data = hit_data_r;
        res_rv        = hit_data_r;
      end
    end else if (act_r == ACT_SET) begin
      do_write = 1'b1;
      if (has_room) begin
        wr_idx    = free_idx_r;
        set_valid = 1'b1;
        fill_inc  = 1'b1;
      end else begin
        res_evicted = 1'b1;
        res_ek      = vic_key_r;
      end
    end else begin
      do_write = 1'b0;
    end
  end
  assign mem_we = ctl.commit && do_write;

  // table state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
      stamp_r <= '0;
    end else if (ctl.commit) begin
      if (set_valid) valid_r[wr_idx] <= 1'b1;
      if (fill_inc) fill_r <= fill_r + 1'b1;
      if (do_write) stamp_r <= stamp_r + 1'b1;
    end
  end

  // output register
  logic  out_valid_r, out_hit_r, out_ev_r;
  word_t out_rv_r, out_ek_r;
  assign out_free = !out_valid_r || out_ch.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (ctl.commit) begin
      out_hit_r <= res_hit;
      out_rv_r  <= res_rv;
      out_ev_r  <= res_evicted;
      out_ek_r  <= res_ek;
    end
  end
  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.read_value  = out_rv_r;
  assign out_ch.evicted     = out_ev_r;
  assign out_ch.evicted_key = out_ek_r;

  // set miss being written back
  logic commit_set_miss;
  assign commit_set_miss = ctl.commit && (act_r == ACT_SET) && !hit_r;

  // checks
  `LFU_ASSERT_ALW(a_fill_bound, fill_r <= FILL_W'(ENTRIES))
  `LFU_ASSERT_IMP(a_commit_slot_free, ctl.commit, !out_valid_r || out_ch.ready)
  `LFU_ASSERT_IMP(a_victim_known, commit_set_miss && !has_room, vic_found_r)
  `LFU_ASSERT_IMP(a_room_has_slot, commit_set_miss && has_room, free_found_r)
  `LFU_ASSERT_NXT(a_commit_shows, ctl.commit, out_valid_r)

endmodule

/* test/lfu_table_checker.sv */
// Passive checker for the LFU table: tracks its own copy of the table, predicts
// one result per request transfer and compares each result transfer against it.
module lfu_table_checker import lfu_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic clk,
  input  logic rst_n,
  lfu_in_if    req_mon,
  lfu_out_if   resp_mon,
  lfu_cfg_if   cap_mon,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic  hit;
    word_t read_value;
    logic  evicted;
    word_t evicted_key;
  } lookup_t;

  // shadow table
  logic    live       [ENTRIES];
  word_t   slot_key   [ENTRIES];
  word_t   slot_data  [ENTRIES];
  cnt_t    slot_uses  [ENTRIES];
  stamp_t  slot_stamp [ENTRIES];
  stamp_t  stamp_next;
  int      filled;
  cfg_t    capacity;
  lookup_t lookup_q[$];

  // new key in a slot: count 1, newest stamp (stamp wraps at its width)
  function automatic void install_key(int s, word_t k, word_t v);
    live[s]       = 1'b1;
    slot_key[s]   = k;
    slot_data[s]  = v;
    slot_uses[s]  = CNT_ONE;
    slot_stamp[s] = stamp_next;
    stamp_next++;
  endfunction

  function automatic lookup_t predict_lookup(logic act, word_t k, word_t v);
    lookup_t r;
    int      lim;
    int      found;
    int      victim;
    r.hit         = 1'b0;
    r.read_value  = '1;
    r.evicted     = 1'b0;
    r.evicted_key = '0;
    // capacity clamped to 1..ENTRIES
    if (capacity == 0) lim = 1;
    else if (int'(capacity) > ENTRIES) lim = ENTRIES;
    else lim = int'(capacity);

    found = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && live[i] && slot_key[i] == k) found = i;
    end

    // hit: get returns data, set overwrites; both bump count and recency
    if (found >= 0) begin
      r.hit = 1'b1;
      if (act == ACT_GET) r.read_value = slot_data[found];
      else slot_data[found] = v;
      if (slot_uses[found] != CNT_MAX) slot_uses[found]++;
      slot_stamp[found] = stamp_next;
      stamp_next++;
      return r;
    end

    if (act == ACT_GET) return r;

    // room left: lowest free slot
    if (filled < lim) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!live[i]) begin
          install_key(i, k, v);
          filled++;
          return r;
        end
      end
    end

    // full: lowest count, oldest stamp among ties, lowest slot last
    victim = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (live[i]) begin
        if (victim < 0 || slot_uses[i] < slot_uses[victim] ||
            (slot_uses[i] == slot_uses[victim] && slot_stamp[i] < slot_stamp[victim]))
          victim = i;
      end
    end
    if (victim >= 0) begin
      r.evicted     = 1'b1;
      r.evicted_key = slot_key[victim];
      install_key(victim, k, v);
    end
    return r;
  endfunction

  // monitor all three channels at the clock edge
  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (!rst_n) begin
      foreach (live[i]) live[i] = 1'b0;
      stamp_next  = '0;
      filled      = 0;
      capacity    = CAP_RESET;
      mismatches  = 0;
      lookup_q.delete();
    end else begin
      if (cap_mon.valid && cap_mon.ready) capacity = cap_mon.data;
      if (req_mon.valid && req_mon.ready)
        lookup_q.push_back(predict_lookup(req_mon.action, req_mon.key, req_mon.write_value));
      if (resp_mon.valid && resp_mon.ready) begin
        got.hit         = resp_mon.hit;
        got.read_value  = resp_mon.read_value;
        got.evicted     = resp_mon.evicted;
        got.evicted_key = resp_mon.evicted_key;
        if (lookup_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transfer with nothing outstanding:", $realtime,
                     " hit=%0b rd=%h ev=%0b evk=%h",
                     got.hit, got.read_value, got.evicted, got.evicted_key);
        end else begin
          want = lookup_q.pop_front();
          if (got.hit !== want.hit || got.read_value !== want.read_value ||
              got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch: exp hit=%0b rd=%h ev=%0b evk=%h,", $realtime,
                       want.hit, want.read_value, want.evicted, want.evicted_key,
                       " got hit=%0b rd=%h ev=%0b evk=%h",
                       got.hit, got.read_value, got.evicted, got.evicted_key);
          end
        end
      end
    end
    outstanding = lookup_q.size();
  end

endmodule

/* test/tb_lfu_cache_table.sv */
module tb_lfu_cache_table import lfu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES      = 16;
  localparam int LIMIT        = 400000;
  localparam int DRAIN_CYCLES = ENTRIES + 8;
  localparam int POOL         = 24;

  logic  clk;
  logic  rst_n;
  int    send_idle_pct;
  int    recv_idle_pct;
  int    cycle_count = 0;
  int    mismatches;
  int    outstanding;
  word_t key_pool[POOL];
  cfg_t  cap_plan[15] = '{5'd16, 5'd1, 5'd8, 5'd31, 5'd3,
                          5'd0, 5'd12, 5'd16, 5'd5, 5'd2,
                          5'd17, 5'd4, 5'd1, 5'd16, 5'd9};

  lfu_in_if  in_if();
  lfu_out_if out_if();
  lfu_cfg_if cfg_if();

  lfu_cache_table #(.ENTRIES(ENTRIES)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  lfu_table_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (in_if),
    .resp_mon    (out_if),
    .cap_mon     (cfg_if),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result-side backpressure
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // one request transfer, with optional idle cycles ahead of it;
  // ready is looked at ahead of the edge that completes the transfer
  task automatic put_request(logic act, word_t k, word_t v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= act;
    in_if.key         <= k;
    in_if.write_value <= v;
    @(negedge clk);
    while (!in_if.ready) @(negedge clk);
    @(posedge clk);
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // capacity write, only with the table idle
  task automatic set_capacity(cfg_t c);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    @(negedge clk);
    while (!cfg_if.ready) @(negedge clk);
    @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // random mix of gets and sets over a key pool sized around the capacity
  task automatic run_block(cfg_t cap, int n);
    int    span;
    logic  act;
    word_t k;
    set_capacity(cap);
    if (cap == 0) span = 1;
    else if (int'(cap) > ENTRIES) span = ENTRIES;
    else span = int'(cap);
    span = span + $urandom_range(1, 8);
    repeat (8) key_pool[$urandom_range(POOL - 1)] = word_t'($urandom);
    repeat (n) begin
      act = $urandom_range(1) ? ACT_SET : ACT_GET;
      // occasional key outside the pool
      if ($urandom_range(9) == 0) k = word_t'($urandom);
      else k = key_pool[$urandom_range(span - 1)];
      put_request(act, k, word_t'($urandom));
    end
  endtask

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.action      = ACT_GET;
    in_if.key         = '0;
    in_if.write_value = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = CAP_RESET;
    send_idle_pct     = 12;
    recv_idle_pct     = 64;
    foreach (key_pool[i]) key_pool[i] = word_t'($urandom);
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = '1;
    key_pool[3] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, extreme keys and values, update in place
    put_request(ACT_GET, '0, 32'h1234_5678);
    put_request(ACT_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    put_request(ACT_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    put_request(ACT_SET, '1, '1);
    put_request(ACT_SET, '0, '0);
    put_request(ACT_GET, 32'h8000_0000, '0);
    put_request(ACT_GET, 32'h7FFF_FFFF, '1);
    put_request(ACT_GET, '1, '0);
    put_request(ACT_SET, '1, 32'h0000_0005);
    put_request(ACT_GET, '1, '0);
    put_request(ACT_GET, 32'h0000_0001, '0);

    // capacity below fill: misses evict lowest count, oldest among ties
    set_capacity(5'd2);
    put_request(ACT_SET, 32'h0000_00A0, 32'h0000_0011);
    put_request(ACT_SET, 32'h0000_00B0, 32'h0000_0022);
    put_request(ACT_GET, 32'h0000_00B0, '0);
    put_request(ACT_SET, 32'h0000_00C0, 32'h0000_0033);

    // zero behaves as one
    set_capacity(5'd0);
    put_request(ACT_SET, 32'h0000_00D0, 32'h0000_0044);
    put_request(ACT_GET, 32'h0000_00C0, '0);

    // above range clamps to the full table, free slots refill
    set_capacity(5'd31);
    repeat (6) put_request(ACT_SET, word_t'($urandom), word_t'($urandom));
    put_request(ACT_GET, 32'h0000_00D0, '0);

    // random phases: sender light/receiver heavy, swapped, then no idling
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int b = 0; b < 5; b++) run_block(cap_plan[ph * 5 + b], 70);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
